// ===== hw/rtl/tibp_pkg.sv =====
// Package for the tape image block parser.
// Holds the item and result types and the codes shared by all modules.
// No dependencies.
package tibp_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] write_addr;
    logic [7:0]  write_data;
    logic [1:0]  status;
    logic [15:0] load_start;
    logic [15:0] code_count;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t data;
  } queue_wr_t;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic RESULT_WRITE  = 1'b0;
  localparam logic RESULT_STATUS = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_NO_CODE   = 2'd3;

  localparam logic [7:0]  FLAG_HEADER = 8'h00;
  localparam logic [7:0]  FLAG_DATA   = 8'hFF;
  localparam logic [7:0]  TYPE_CODE   = 8'd3;
  localparam logic [15:0] HEADER_LEN  = 16'd19;
  localparam logic [15:0] MIN_LEN     = 16'd2;
  localparam logic [4:0]  HDR_LAST    = 5'd17;
  localparam logic [4:0]  HDR_ADDR_LO = 5'd13;
  localparam logic [4:0]  HDR_ADDR_HI = 5'd14;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

endpackage

// ===== hw/rtl/tibp_parser.sv =====
// Front part of the tape image block parser: block state machine.
// Classifies each accepted byte and produces write and status results.
// Depends on tibp_pkg.
module tibp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  tibp_pkg::item_t     item,
  input  logic                load_enable,
  output tibp_pkg::queue_wr_t wr
);
  import tibp_pkg::*;

  localparam logic [2:0] PH_LEN_LO   = 3'd0;
  localparam logic [2:0] PH_LEN_HI   = 3'd1;
  localparam logic [2:0] PH_FLAG     = 3'd2;
  localparam logic [2:0] PH_HEADER   = 3'd3;
  localparam logic [2:0] PH_PAYLOAD  = 3'd4;
  localparam logic [2:0] PH_CHECKSUM = 3'd5;
  localparam logic [2:0] PH_SKIP     = 3'd6;
  localparam logic [2:0] PH_HALT     = 3'd7;

  logic [2:0]  phase, phase_next;
  logic [7:0]  len_lo, len_lo_next;
  logic [15:0] block_length, block_length_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [4:0]  header_index, header_index_next;
  logic [7:0]  header_type, header_type_next;
  logic [15:0] pending_addr, pending_addr_next;
  logic        pending_code, pending_code_next;
  logic [15:0] write_addr, write_addr_next;
  logic [15:0] first_addr, first_addr_next;
  logic        first_known, first_known_next;
  logic [15:0] code_total, code_total_next;
  logic [1:0]  error_code, error_code_next;

  logic [15:0] new_length;
  logic [15:0] data_length;
  logic [1:0]  end_status;
  logic [7:0]  b;

  assign b           = item.byte_value;
  assign new_length  = {b, len_lo};
  assign data_length = block_length - MIN_LEN;

  always_comb begin
    if (error_code != ST_OK) begin
      end_status = error_code;
    end else if (phase != PH_LEN_LO) begin
      end_status = ST_TRUNCATED;
    end else if (load_enable && code_total == 16'd0) begin
      end_status = ST_NO_CODE;
    end else begin
      end_status = ST_OK;
    end
  end

  always_comb begin
    phase_next        = phase;
    len_lo_next       = len_lo;
    block_length_next = block_length;
    bytes_left_next   = bytes_left;
    header_index_next = header_index;
    header_type_next  = header_type;
    pending_addr_next = pending_addr;
    pending_code_next = pending_code;
    write_addr_next   = write_addr;
    first_addr_next   = first_addr;
    first_known_next  = first_known;
    code_total_next   = code_total;
    error_code_next   = error_code;
    wr                = '0;
    if (accept) begin
      if (item.kind == KIND_END) begin
        wr.push             = 1'b1;
        wr.data.result_kind = RESULT_STATUS;
        wr.data.status      = end_status;
        if (end_status == ST_OK) begin
          wr.data.load_start = first_known ? first_addr : 16'd0;
          wr.data.code_count = code_total;
        end
        phase_next        = PH_LEN_LO;
        len_lo_next       = '0;
        block_length_next = '0;
        bytes_left_next   = '0;
        header_index_next = '0;
        header_type_next  = '0;
        pending_addr_next = '0;
        pending_code_next = 1'b0;
        write_addr_next   = '0;
        first_addr_next   = '0;
        first_known_next  = 1'b0;
        code_total_next   = '0;
        error_code_next   = ST_OK;
      end else begin
        case (phase)
          PH_LEN_LO: begin
            len_lo_next = b;
            phase_next  = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            block_length_next = new_length;
            if (new_length < MIN_LEN) begin
              error_code_next = ST_MALFORMED;
              phase_next      = PH_HALT;
            end else begin
              phase_next = PH_FLAG;
            end
          end
          PH_FLAG: begin
            if (b == FLAG_HEADER && block_length == HEADER_LEN) begin
              header_index_next = '0;
              phase_next        = PH_HEADER;
            end else if (b == FLAG_DATA) begin
              bytes_left_next = data_length;
              write_addr_next = pending_addr;
              if (pending_code && load_enable && !first_known) begin
                first_addr_next  = pending_addr;
                first_known_next = 1'b1;
              end
              phase_next = (data_length != 16'd0) ? PH_PAYLOAD : PH_CHECKSUM;
            end else begin
              bytes_left_next = block_length - 16'd1;
              phase_next      = PH_SKIP;
            end
          end
          PH_HEADER: begin
            if (header_index == 5'd0) begin
              header_type_next = b;
            end else if (header_index == HDR_ADDR_LO) begin
              pending_addr_next = {pending_addr[15:8], b};
            end else if (header_index == HDR_ADDR_HI) begin
              pending_addr_next = {b, pending_addr[7:0]};
            end
            if (header_index >= HDR_LAST) begin
              pending_code_next = (header_type == TYPE_CODE);
              header_index_next = '0;
              phase_next        = PH_LEN_LO;
            end else begin
              header_index_next = header_index + 5'd1;
            end
          end
          PH_PAYLOAD: begin
            write_addr_next = write_addr + 16'd1;
            bytes_left_next = bytes_left - 16'd1;
            if (bytes_left == 16'd1) begin
              phase_next = PH_CHECKSUM;
            end
            if (pending_code && load_enable) begin
              wr.push             = 1'b1;
              wr.data.result_kind = RESULT_WRITE;
              wr.data.write_addr  = write_addr;
              wr.data.write_data  = b;
            end
          end
          PH_CHECKSUM: begin
            if (pending_code && code_total != COUNT_MAX) begin
              code_total_next = code_total + 16'd1;
            end
            pending_code_next = 1'b0;
            phase_next        = PH_LEN_LO;
          end
          PH_SKIP: begin
            bytes_left_next = bytes_left - 16'd1;
            if (bytes_left == 16'd1) begin
              phase_next = PH_LEN_LO;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LEN_LO;
      len_lo       <= '0;
      block_length <= '0;
      bytes_left   <= '0;
      header_index <= '0;
      header_type  <= '0;
      pending_addr <= '0;
      pending_code <= 1'b0;
      write_addr   <= '0;
      first_addr   <= '0;
      first_known  <= 1'b0;
      code_total   <= '0;
      error_code   <= ST_OK;
    end else begin
      phase        <= phase_next;
      len_lo       <= len_lo_next;
      block_length <= block_length_next;
      bytes_left   <= bytes_left_next;
      header_index <= header_index_next;
      header_type  <= header_type_next;
      pending_addr <= pending_addr_next;
      pending_code <= pending_code_next;
      write_addr   <= write_addr_next;
      first_addr   <= first_addr_next;
      first_known  <= first_known_next;
      code_total   <= code_total_next;
      error_code   <= error_code_next;
    end
  end

  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    (error_code != ST_OK) |-> (phase == PH_HALT))
    else $error("error recorded outside the halt phase");

  a_header_index_range: assert property (@(posedge clk) disable iff (rst)
    header_index <= HDR_LAST)
    else $error("header index beyond the last header byte");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && item.kind == KIND_END) |=>
      (phase == PH_LEN_LO && code_total == 16'd0 && !first_known))
    else $error("state not cleared after end of stream");

  a_write_only_payload: assert property (@(posedge clk) disable iff (rst)
    (wr.push && wr.data.result_kind == RESULT_WRITE) |->
      (phase == PH_PAYLOAD && load_enable && pending_code))
    else $error("memory write outside a loaded code payload");

endmodule

// ===== hw/rtl/tibp_queue.sv =====
// Back part of the tape image block parser: result queue and output stage.
// Holds results until the receiver takes them. Depends on tibp_pkg.
module tibp_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  tibp_pkg::queue_wr_t wr,
  output logic                full,
  output logic                valid,
  input  logic                stall,
  output tibp_pkg::result_t   data
);
  import tibp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  result_t           mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              pop;

  assign pop   = valid && !stall;
  assign valid = (count != '0);
  assign full  = (count == FULL_CNT);
  assign data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem[wr_ptr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({wr.push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr.push && full))
    else $error("push into a full result queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("result queue count out of range");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (wr.push && !pop) |=> (count == $past(count) + CNT_W'(1)))
    else $error("result queue count missed a push");

endmodule

// ===== hw/rtl/tape_image_block_parser_top.sv =====
// Top level of the tape image block parser.
// Connects the parser front end to the result queue. Depends on tibp_pkg,
// tibp_parser and tibp_queue.
//
// The input channel carries one tape image byte or an end-of-stream mark per
// transfer (in_valid, in_stall, in_item). Each block is parsed as it streams
// by; payload bytes of a code block become memory write results while
// load_enable is set, and the end-of-stream mark yields one status result
// with the first load address and the code block count (when the status is
// OK), then clears the parser state. Other items produce no result.
// The block takes one byte per cycle while in_stall is low. A result is
// registered in the queue and shown on the output channel (out_valid,
// out_stall, out_item) once older results are taken. The result queue holds
// QUEUE_DEPTH results; when the receiver stalls, the queue fills and
// in_stall rises once it is full; the input then waits until a result is taken.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes
// load_enable and is always ready. Reset clears the parser state, empties
// the queue and sets load_enable to 0.
module tape_image_block_parser_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  tibp_pkg::item_t   in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output tibp_pkg::result_t out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);
  import tibp_pkg::*;

  logic      load_enable;
  logic      queue_full;
  logic      in_accept;
  queue_wr_t wr;

  assign cfg_ready = 1'b1;
  assign in_stall  = queue_full;
  assign in_accept = in_valid && !queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      load_enable <= cfg_data;
    end
  end

  tibp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .item        (in_item),
    .load_enable (load_enable),
    .wr          (wr)
  );

  tibp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .full  (queue_full),
    .valid (out_valid),
    .stall (out_stall),
    .data  (out_item)
  );

endmodule
